[design/svpwm_pkg.sv]
`timescale 1ns / 1ps
// svpwm_pkg: shared types and constants of the space vector pwm duty unit
package svpwm_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_QQ,
        ST_MUL_DD,
        ST_MUL_VV,
        ST_LIM,
        ST_LIM_H,
        ST_LIM_R,
        ST_SQRT,
        ST_LM_MUL,
        ST_LM_DIV,
        ST_UN_MUL1,
        ST_UN_MUL2,
        ST_UN_DIV,
        ST_AXIS_DONE,
        ST_ROT_INIT,
        ST_ROT,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_S,
        ST_SECT,
        ST_OVCHK,
        ST_OV_DIV4,
        ST_OV4_DONE,
        ST_OV_DIV6,
        ST_OV6_DONE,
        ST_DIV,
        ST_FINISH
    } t_state;

    // configuration register indexes
    localparam logic CFG_BUS_VOLTAGE = 1'b0;
    localparam logic CFG_PWM_PERIOD  = 1'b1;

    localparam logic [15:0] BUS_VOLTAGE_RST = 16'd6144;
    localparam logic [15:0] PWM_PERIOD_RST  = 16'd4250;

    localparam int FRAC       = 12;
    localparam int ROT_STEPS  = 20;
    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;

    // sqrt(3) and inverse cordic gain, both q30
    localparam logic [30:0] SQRT3_Q30 = 31'd1859775393;
    localparam logic [30:0] INVK_Q30  = 31'd652032874;

    // 2^89 / sqrt3_q30 rounded up: exact circle radius term for any 16-bit period
    localparam logic [58:0] RADIUS_RECIP =
        59'(((128'd1 << 89) / 128'(SQRT3_Q30)) + 128'd1);

    // arctangent of 2^-i, 2^32 per turn
    localparam logic [30:0] ROT_ATAN [ROT_STEPS] = '{
        31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756, 31'd42667331,
        31'd21354465,  31'd10679838,  31'd5340245,   31'd2670163,  31'd1335087,
        31'd667544,    31'd333772,    31'd166886,    31'd83443,    31'd41722,
        31'd20861,     31'd10430,     31'd5215,      31'd2608,     31'd1304
    };

endpackage

[design/svpwm_sector_duty_unit.sv]
`timescale 1ns / 1ps
// svpwm_sector_duty_unit: seven-segment space vector pwm compare value generator
//
// One transaction on the slave stream carries a d/q voltage command and an electrical
// angle; one transaction on the master stream returns the three phase compare values,
// the sector and two limit flags. All arithmetic runs through one shared 33x33 signed
// multiplier, one bit-serial restoring divider, a bit-serial square root and a 20-step
// cordic rotator under a small sequencer, so the block takes one transaction at a time.
// A command outside the circle is pulled onto it (the radius term comes from a two-pass
// reciprocal multiply), and the active times are rescaled when their sum exceeds the
// period. The quotient loop of the divider takes most of the processing time. The
// finished result sits in an output register, so a new item is accepted while the
// previous result still waits for tready. Configuration writes are expected only while
// the block is idle.
module svpwm_sector_duty_unit #(
    parameter int ANGLE_BITS   = 16,
    parameter int COMPARE_BITS = 16,
    parameter int TOP_MARGIN   = 50
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    // command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // volt_q[15:0], volt_d[31:16], elec_angle[47:32]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // compare_a[15:0], compare_b[31:16],
                                        // compare_c[47:32], sector_num[50:48],
                                        // circle_limited[51], overmod_scaled[52]
);

    localparam logic [31:0] ANGLE_MASK  = 32'((64'd1 << ANGLE_BITS) - 64'd1);
    localparam int          ANGLE_SHIFT = 32 - ANGLE_BITS;

    // configuration
    logic [15:0] r_bus, r_period;

    // sequencer
    svpwm_pkg::t_state r_state, n_state, r_ret, n_ret;
    logic [6:0]  r_cnt, n_cnt;

    // latched command
    logic signed [15:0] r_vq, n_vq, r_vd, n_vd;
    logic [15:0] r_angle, n_angle;

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] r_prod;

    // magnitude and limit
    logic [31:0] r_sumsq, n_sumsq;
    logic        r_lim, n_lim, r_axis, n_axis;
    logic [27:0] r_rr, n_rr;
    logic [47:0] r_rlo, n_rlo;
    logic [74:0] rr_sum;

    // square root
    logic [63:0] r_sn, n_sn, r_sr, n_sr, r_sbit, n_sbit;
    logic [63:0] sq_t;

    // divider
    logic [63:0] r_quo, n_quo;
    logic [36:0] r_rem, n_rem;
    logic [35:0] r_dsor, n_dsor;
    logic        r_qneg, n_qneg;
    logic        div_start;
    logic [63:0] div_dividend;
    logic [35:0] div_divisor;
    svpwm_pkg::t_state div_ret;
    logic [36:0] rem_sh;
    logic [63:0] q_val;

    // rotation and sector
    logic signed [33:0] r_ud, n_ud, r_uq, n_uq;
    logic signed [33:0] r_x, n_x, r_y, n_y, r_z, n_z;
    logic signed [33:0] r_alpha, n_alpha, r_beta, n_beta;
    logic signed [35:0] r_t4, n_t4, r_t6, n_t6;
    logic [35:0] r_s, n_s;
    logic [2:0]  r_n, n_n, r_sector, n_sector;
    logic        r_ov, n_ov;

    // held compare values and output register
    logic [COMPARE_BITS-1:0] r_held [3];
    logic [COMPARE_BITS-1:0] n_held [3];
    logic        r_out_valid, n_out_valid;
    logic [55:0] r_out_data, n_out_data;

    // helpers
    logic [15:0] v_eff;
    logic signed [15:0] v_axis;
    logic [27:0] pf;
    logic [31:0] a32, fold_q, a_rot;
    logic        fold_neg;
    logic signed [33:0] dx, dy;
    logic signed [33:0] atan_w;
    logic        lim_c;

    // sector logic
    logic signed [35:0] sb, ss, xs, ys, zs;
    logic [2:0]  code, sect_c;
    logic signed [35:0] t4_c, t6_c;
    logic signed [36:0] ov_sum;

    // switching times
    logic signed [39:0] pfw, t4w, t6w, ta, tb, tc, ta12, tb12, tc12;
    logic signed [39:0] cv [3];
    logic signed [39:0] cl [3];
    logic signed [17:0] hi_raw, hi;

    assign s_axis_tready = (r_state == svpwm_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign v_eff  = (r_bus == 16'd0) ? 16'd1 : r_bus;
    assign v_axis = r_axis ? r_vq : r_vd;
    assign pf     = {r_period, 12'd0};

    // radius term: (P*recip_hi*2^32 + P*recip_lo) >> 47
    assign rr_sum = {r_prod[42:0], 32'd0} + {27'd0, r_rlo};

    // angle fold into +-90 degrees
    assign a32      = ({16'd0, r_angle} & ANGLE_MASK) << ANGLE_SHIFT;
    assign fold_q   = a32 + 32'h4000_0000;
    assign fold_neg = fold_q[31];
    assign a_rot    = fold_neg ? (a32 + 32'h8000_0000) : a32;

    // one cordic step
    assign dx     = r_y >>> r_cnt[4:0];
    assign dy     = r_x >>> r_cnt[4:0];
    assign atan_w = $signed({3'd0, svpwm_pkg::ROT_ATAN[r_cnt[4:0]]});

    // one square root step
    assign sq_t = r_sr + r_sbit;

    // one divider step
    assign rem_sh = {r_rem[35:0], r_quo[63]};
    assign q_val  = r_qneg ? (~r_quo + 64'd1) : r_quo;

    // limit test: 9*sumsq > V^2
    assign lim_c = ({4'd0, r_sumsq} + {1'b0, r_sumsq, 3'd0}) > r_prod[35:0];

    // sector from sign code
    always_comb begin
        sb = {{2{r_beta[33]}}, r_beta};
        ss = {{2{r_prod[63]}}, r_prod[63:30]};
        code = {(-ss - sb) > 36'sd0, (ss - sb) > 36'sd0, sb > 36'sd0};
        xs = sb;
        ys = (ss + sb) >>> 1;
        zs = (sb - ss) >>> 1;
        t4_c = '0;
        t6_c = '0;
        sect_c = 3'd0;
        case (code)
            3'd1: begin t4_c = zs;  t6_c = ys;  sect_c = 3'd2; end
            3'd2: begin t4_c = ys;  t6_c = -xs; sect_c = 3'd6; end
            3'd3: begin t4_c = -zs; t6_c = xs;  sect_c = 3'd1; end
            3'd4: begin t4_c = -xs; t6_c = zs;  sect_c = 3'd4; end
            3'd5: begin t4_c = xs;  t6_c = -ys; sect_c = 3'd3; end
            3'd6: begin t4_c = -ys; t6_c = -zs; sect_c = 3'd5; end
            default: begin t4_c = '0; t6_c = '0; sect_c = 3'd0; end
        endcase
    end

    assign ov_sum = {r_t4[35], r_t4} + {r_t6[35], r_t6};

    // switching times, phase mapping and clamp
    always_comb begin
        pfw  = $signed({12'd0, r_period, 12'd0});
        t4w  = {{4{r_t4[35]}}, r_t4};
        t6w  = {{4{r_t6[35]}}, r_t6};
        ta   = (pfw - t4w - t6w) >>> 2;
        tb   = ta + (t4w >>> 1);
        tc   = tb + (t6w >>> 1);
        ta12 = ta >>> svpwm_pkg::FRAC;
        tb12 = tb >>> svpwm_pkg::FRAC;
        tc12 = tc >>> svpwm_pkg::FRAC;
        hi_raw = $signed({2'd0, r_period}) - 18'(TOP_MARGIN);
        hi     = (hi_raw < 18'sd1) ? 18'sd1 : hi_raw;
        if (r_sector == 3'd0) begin
            for (int k = 0; k < 3; k++) begin
                cv[k] = $signed(40'(r_held[k]));
            end
        end else begin
            case (r_n)
                3'd1: begin cv[0] = tb12; cv[1] = ta12; cv[2] = tc12; end
                3'd2: begin cv[0] = ta12; cv[1] = tc12; cv[2] = tb12; end
                3'd3: begin cv[0] = ta12; cv[1] = tb12; cv[2] = tc12; end
                3'd4: begin cv[0] = tc12; cv[1] = tb12; cv[2] = ta12; end
                3'd5: begin cv[0] = tc12; cv[1] = ta12; cv[2] = tb12; end
                default: begin cv[0] = tb12; cv[1] = tc12; cv[2] = ta12; end
            endcase
        end
        for (int k = 0; k < 3; k++) begin
            if (cv[k] < 40'sd1) begin
                cl[k] = 40'sd1;
            end else if (cv[k] > 40'(hi)) begin
                cl[k] = 40'(hi);
            end else begin
                cl[k] = cv[k];
            end
        end
    end

    // sequencer: next state, multiplier operands and datapath updates
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_cnt   = r_cnt;
        n_vq    = r_vq;
        n_vd    = r_vd;
        n_angle = r_angle;
        n_sumsq = r_sumsq;
        n_lim   = r_lim;
        n_axis  = r_axis;
        n_rr    = r_rr;
        n_rlo   = r_rlo;
        n_sn    = r_sn;
        n_sr    = r_sr;
        n_sbit  = r_sbit;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dsor  = r_dsor;
        n_qneg  = r_qneg;
        n_ud    = r_ud;
        n_uq    = r_uq;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_alpha = r_alpha;
        n_beta  = r_beta;
        n_t4    = r_t4;
        n_t6    = r_t6;
        n_s     = r_s;
        n_n     = r_n;
        n_sector = r_sector;
        n_ov    = r_ov;
        n_held  = r_held;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid & ~m_axis_tready;
        mul_a = '0;
        mul_b = '0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        div_ret      = svpwm_pkg::ST_IDLE;

        case (r_state)
            svpwm_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_vq    = s_axis_tdata[15:0];
                    n_vd    = s_axis_tdata[31:16];
                    n_angle = s_axis_tdata[47:32];
                    n_state = svpwm_pkg::ST_MUL_QQ;
                end
            end
            svpwm_pkg::ST_MUL_QQ: begin
                mul_a   = {{17{r_vq[15]}}, r_vq};
                mul_b   = {{17{r_vq[15]}}, r_vq};
                n_state = svpwm_pkg::ST_MUL_DD;
            end
            svpwm_pkg::ST_MUL_DD: begin
                n_sumsq = r_prod[31:0];
                mul_a   = {{17{r_vd[15]}}, r_vd};
                mul_b   = {{17{r_vd[15]}}, r_vd};
                n_state = svpwm_pkg::ST_MUL_VV;
            end
            svpwm_pkg::ST_MUL_VV: begin
                n_sumsq = r_sumsq + r_prod[31:0];
                mul_a   = {17'd0, v_eff};
                mul_b   = {17'd0, v_eff};
                n_state = svpwm_pkg::ST_LIM;
            end
            svpwm_pkg::ST_LIM: begin
                n_lim  = lim_c;
                n_axis = 1'b0;
                if (lim_c) begin
                    // circle radius term P*2^12 / sqrt3, low reciprocal half first
                    mul_a   = {17'd0, r_period};
                    mul_b   = {1'b0, svpwm_pkg::RADIUS_RECIP[31:0]};
                    n_state = svpwm_pkg::ST_LIM_H;
                end else begin
                    n_state = svpwm_pkg::ST_UN_MUL1;
                end
            end
            svpwm_pkg::ST_LIM_H: begin
                n_rlo   = r_prod[47:0];
                mul_a   = {17'd0, r_period};
                mul_b   = {6'd0, svpwm_pkg::RADIUS_RECIP[58:32]};
                n_state = svpwm_pkg::ST_LIM_R;
            end
            svpwm_pkg::ST_LIM_R: begin
                n_rr    = rr_sum[74:47];
                n_sn    = {2'd0, r_sumsq, 30'd0};
                n_sr    = '0;
                n_sbit  = 64'd1 << 62;
                n_cnt   = '0;
                n_state = svpwm_pkg::ST_SQRT;
            end
            svpwm_pkg::ST_SQRT: begin
                if (r_sn >= sq_t) begin
                    n_sn = r_sn - sq_t;
                    n_sr = (r_sr >> 1) + r_sbit;
                end else begin
                    n_sr = r_sr >> 1;
                end
                n_sbit = r_sbit >> 2;
                n_cnt  = r_cnt + 7'd1;
                if (r_cnt == 7'(svpwm_pkg::SQRT_STEPS - 1)) begin
                    n_state = svpwm_pkg::ST_LM_MUL;
                end
            end
            svpwm_pkg::ST_LM_MUL: begin
                mul_a   = {{17{v_axis[15]}}, v_axis};
                mul_b   = {5'd0, r_rr};
                n_state = svpwm_pkg::ST_LM_DIV;
            end
            svpwm_pkg::ST_LM_DIV: begin
                div_start    = 1'b1;
                div_dividend = {r_prod[48:0], 15'd0};
                div_divisor  = {5'd0, r_sr[30:0]};
                div_ret      = svpwm_pkg::ST_AXIS_DONE;
            end
            svpwm_pkg::ST_UN_MUL1: begin
                mul_a   = {{17{v_axis[15]}}, v_axis};
                mul_b   = {17'd0, r_period};
                n_state = svpwm_pkg::ST_UN_MUL2;
            end
            svpwm_pkg::ST_UN_MUL2: begin
                mul_a   = {r_prod[31], r_prod[31:0]};
                mul_b   = {2'd0, svpwm_pkg::SQRT3_Q30};
                n_state = svpwm_pkg::ST_UN_DIV;
            end
            svpwm_pkg::ST_UN_DIV: begin
                div_start    = 1'b1;
                div_dividend = r_prod[63:0];
                div_divisor  = {2'd0, v_eff, 18'd0};
                div_ret      = svpwm_pkg::ST_AXIS_DONE;
            end
            svpwm_pkg::ST_AXIS_DONE: begin
                if (!r_axis) begin
                    n_ud    = q_val[33:0];
                    n_axis  = 1'b1;
                    n_state = r_lim ? svpwm_pkg::ST_LM_MUL : svpwm_pkg::ST_UN_MUL1;
                end else begin
                    n_uq    = q_val[33:0];
                    n_state = svpwm_pkg::ST_ROT_INIT;
                end
            end
            svpwm_pkg::ST_ROT_INIT: begin
                n_x     = fold_neg ? -r_ud : r_ud;
                n_y     = fold_neg ? -r_uq : r_uq;
                n_z     = {{2{a_rot[31]}}, a_rot};
                n_cnt   = '0;
                n_state = svpwm_pkg::ST_ROT;
            end
            svpwm_pkg::ST_ROT: begin
                if (!r_z[33]) begin
                    n_x = r_x - dx;
                    n_y = r_y + dy;
                    n_z = r_z - atan_w;
                end else begin
                    n_x = r_x + dx;
                    n_y = r_y - dy;
                    n_z = r_z + atan_w;
                end
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'(svpwm_pkg::ROT_STEPS - 1)) begin
                    n_state = svpwm_pkg::ST_MUL_A;
                end
            end
            svpwm_pkg::ST_MUL_A: begin
                mul_a   = r_x[32:0];
                mul_b   = {2'd0, svpwm_pkg::INVK_Q30};
                n_state = svpwm_pkg::ST_MUL_B;
            end
            svpwm_pkg::ST_MUL_B: begin
                n_alpha = r_prod[63:30];
                mul_a   = r_y[32:0];
                mul_b   = {2'd0, svpwm_pkg::INVK_Q30};
                n_state = svpwm_pkg::ST_MUL_S;
            end
            svpwm_pkg::ST_MUL_S: begin
                n_beta  = r_prod[63:30];
                mul_a   = r_alpha[32:0];
                mul_b   = {2'd0, svpwm_pkg::SQRT3_Q30};
                n_state = svpwm_pkg::ST_SECT;
            end
            svpwm_pkg::ST_SECT: begin
                n_t4     = t4_c;
                n_t6     = t6_c;
                n_n      = code;
                n_sector = sect_c;
                n_ov     = 1'b0;
                n_state  = (sect_c == 3'd0) ? svpwm_pkg::ST_FINISH : svpwm_pkg::ST_OVCHK;
            end
            svpwm_pkg::ST_OVCHK: begin
                if (ov_sum > $signed({9'd0, pf})) begin
                    n_s     = ov_sum[35:0];
                    n_ov    = 1'b1;
                    mul_a   = {5'd0, pf};
                    mul_b   = r_t4[32:0];
                    n_state = svpwm_pkg::ST_OV_DIV4;
                end else begin
                    n_state = svpwm_pkg::ST_FINISH;
                end
            end
            svpwm_pkg::ST_OV_DIV4: begin
                div_start    = 1'b1;
                div_dividend = r_prod[63:0];
                div_divisor  = r_s;
                div_ret      = svpwm_pkg::ST_OV4_DONE;
            end
            svpwm_pkg::ST_OV4_DONE: begin
                n_t4    = q_val[35:0];
                mul_a   = {5'd0, pf};
                mul_b   = r_t6[32:0];
                n_state = svpwm_pkg::ST_OV_DIV6;
            end
            svpwm_pkg::ST_OV_DIV6: begin
                div_start    = 1'b1;
                div_dividend = r_prod[63:0];
                div_divisor  = r_s;
                div_ret      = svpwm_pkg::ST_OV6_DONE;
            end
            svpwm_pkg::ST_OV6_DONE: begin
                n_t6    = q_val[35:0];
                n_state = svpwm_pkg::ST_FINISH;
            end
            svpwm_pkg::ST_DIV: begin
                // restoring step, quotient bits shift in behind the dividend
                if (rem_sh >= {1'b0, r_dsor}) begin
                    n_rem = rem_sh - {1'b0, r_dsor};
                    n_quo = {r_quo[62:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_quo = {r_quo[62:0], 1'b0};
                end
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'(svpwm_pkg::DIV_STEPS - 1)) begin
                    n_state = r_ret;
                end
            end
            svpwm_pkg::ST_FINISH: begin
                // wait here only while the previous result is still unread
                if (!r_out_valid || m_axis_tready) begin
                    for (int k = 0; k < 3; k++) begin
                        n_held[k] = cl[k][COMPARE_BITS-1:0];
                    end
                    n_out_data  = {3'd0, r_ov, r_lim, r_sector,
                                   16'(n_held[2]), 16'(n_held[1]), 16'(n_held[0])};
                    n_out_valid = 1'b1;
                    n_state     = svpwm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = svpwm_pkg::ST_IDLE;
            end
        endcase

        // load the divider with magnitudes, sign applied on the way out
        if (div_start) begin
            n_quo   = div_dividend[63] ? (~div_dividend + 64'd1) : div_dividend;
            n_qneg  = div_dividend[63];
            n_dsor  = div_divisor;
            n_rem   = '0;
            n_cnt   = '0;
            n_ret   = div_ret;
            n_state = svpwm_pkg::ST_DIV;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= svpwm_pkg::ST_IDLE;
            r_ret       <= svpwm_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_bus       <= svpwm_pkg::BUS_VOLTAGE_RST;
            r_period    <= svpwm_pkg::PWM_PERIOD_RST;
            for (int k = 0; k < 3; k++) begin
                r_held[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_out_valid <= n_out_valid;
            r_held      <= n_held;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    svpwm_pkg::CFG_BUS_VOLTAGE: r_bus    <= i_cfg_data;
                    svpwm_pkg::CFG_PWM_PERIOD:  r_period <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod     <= mul_a * mul_b;
        r_cnt      <= n_cnt;
        r_vq       <= n_vq;
        r_vd       <= n_vd;
        r_angle    <= n_angle;
        r_sumsq    <= n_sumsq;
        r_lim      <= n_lim;
        r_axis     <= n_axis;
        r_rr       <= n_rr;
        r_rlo      <= n_rlo;
        r_sn       <= n_sn;
        r_sr       <= n_sr;
        r_sbit     <= n_sbit;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_dsor     <= n_dsor;
        r_qneg     <= n_qneg;
        r_ud       <= n_ud;
        r_uq       <= n_uq;
        r_x        <= n_x;
        r_y        <= n_y;
        r_z        <= n_z;
        r_alpha    <= n_alpha;
        r_beta     <= n_beta;
        r_t4       <= n_t4;
        r_t6       <= n_t6;
        r_s        <= n_s;
        r_n        <= n_n;
        r_sector   <= n_sector;
        r_ov       <= n_ov;
        r_out_data <= n_out_data;
    end

endmodule
